// ----- src/sleep_timer_queue_defines.svh -----
// Assertion macros for the sleep timer queue.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef SLEEP_TIMER_QUEUE_DEFINES_SVH
`define SLEEP_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define STQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stq assertion failed");
// next-cycle implication
`define STQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stq assertion failed");
`else
`define STQ_ASSERT_IMPL(label, ante, cons)
`define STQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/stq_pkg.sv -----
// Shared types and constants of the sleep timer queue.
// No dependencies.
`default_nettype none
package stq_pkg;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIME_W      = 40;
  localparam int unsigned ID_W        = 6;
  localparam int unsigned SECS_W      = 16;
  localparam int unsigned NUM_IDS     = 1 << ID_W;
  localparam int unsigned USPS_W      = 20;
  localparam int unsigned PROD_W      = (SECS_W - 1) + USPS_W;
  localparam logic [USPS_W-1:0] US_PER_SEC = USPS_W'(1000000);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_SECONDS = 2'd1,
    ST_FULL        = 2'd2,
    ST_ASLEEP      = 2'd3
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] wake_time;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ----- src/stq_if.sv -----
// Valid/ready channel interfaces: sleep/tick words in, result words out.
// Depends on stq_pkg.
`default_nettype none
interface stq_in_if import stq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ID_W-1:0]          proc_id;
  logic signed [SECS_W-1:0] sleep_seconds;
  logic [TIME_W-1:0]        now_us;
  modport source (output valid, func, proc_id, sleep_seconds, now_us, input ready);
  modport sink   (input valid, func, proc_id, sleep_seconds, now_us, output ready);
endinterface

interface stq_out_if import stq_pkg::*;;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic            woke;
  logic [ID_W-1:0] woke_id;
  modport source (output valid, status, woke, woke_id, input ready);
  modport sink   (input valid, status, woke, woke_id, output ready);
endinterface
`default_nettype wire

// ----- src/sleep_timer_queue.sv -----
// Sleep timer queue top level: sorted wake-up queue on a chain of shift cells.
// A word passes the multiply, add/saturate and apply states; the result word is
// registered on apply, and a new word is accepted only when the block is idle.
// Reset: entry count and asleep flags clear at once; slot contents are not reset.
// Depends on stq_pkg, stq_if, stq_chain and sleep_timer_queue_defines.svh.
`default_nettype none
`include "sleep_timer_queue_defines.svh"
module sleep_timer_queue import stq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stq_in_if.sink    sleep_i,
  stq_out_if.source result_o
);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_APPLY} state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [NUM_IDS-1:0] flags_q, flags_d;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic               woke_q, woke_d;
  logic [ID_W-1:0]    woke_id_q, woke_id_d;

  // captured input word and arithmetic pipeline
  logic                     func_q;
  logic [ID_W-1:0]          id_q;
  logic signed [SECS_W-1:0] secs_q;
  logic [TIME_W-1:0]        now_q;
  logic [PROD_W-1:0]        prod_q;
  logic [TIME_W-1:0]        wake_q;
  logic [TIME_W:0]          sum;

  cell_cmd_t cmd;
  entry_t    head;
  logic      accept;
  logic      fire;

  assign sleep_i.ready   = (state_q == S_IDLE);
  assign accept          = sleep_i.valid && sleep_i.ready;
  // apply only when the output register is free or being drained
  assign fire            = (state_q == S_APPLY) && (!out_valid_q || result_o.ready);

  assign result_o.valid   = out_valid_q;
  assign result_o.status  = status_q;
  assign result_o.woke    = woke_q;
  assign result_o.woke_id = woke_id_q;

  // wake = now + seconds * 1e6, held at the top of the time range
  assign sum = {1'b0, now_q} + (TIME_W + 1)'(prod_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= sleep_i.func;
      id_q   <= sleep_i.proc_id;
      secs_q <= sleep_i.sleep_seconds;
      now_q  <= sleep_i.now_us;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(secs_q[SECS_W-2:0]) * PROD_W'(US_PER_SEC);
    end
    if (state_q == S_ADD) begin
      wake_q <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end
  end

  stq_chain u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .count_i (count_q),
    .head_o  (head)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    flags_d       = flags_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    status_d      = status_q;
    woke_d        = woke_q;
    woke_id_d     = woke_id_q;
    cmd.ins       = 1'b0;
    cmd.pop       = 1'b0;
    cmd.new_entry = '{wake_time: wake_q, id: id_q};

    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ADD;
      end
      S_ADD: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          woke_d      = 1'b0;
          woke_id_d   = '0;
          if (func_q) begin
            // fault priority: bad delay, then already asleep, then full
            if (secs_q[SECS_W-1] || (secs_q == '0)) begin
              status_d = ST_BAD_SECONDS;
            end else if (flags_q[id_q]) begin
              status_d = ST_ASLEEP;
            end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              cmd.ins        = 1'b1;
              count_d        = count_q + 1'b1;
              flags_d[id_q]  = 1'b1;
            end
          end else if ((count_q != '0) && (head.wake_time <= now_q)) begin
            // one due sleeper per tick
            cmd.pop          = 1'b1;
            count_d          = count_q - 1'b1;
            flags_d[head.id] = 1'b0;
            woke_d           = 1'b1;
            woke_id_d        = head.id;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      woke_q      <= 1'b0;
      woke_id_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      woke_q      <= woke_d;
      woke_id_q   <= woke_id_d;
    end
  end

  `STQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
  `STQ_ASSERT_IMPL(a_flags_match, 1'b1, $countones(flags_q) == int'(count_q))
  `STQ_ASSERT_NEXT(a_pop_dec, fire && cmd.pop, count_q == $past(count_q) - 1'b1)
endmodule
`default_nettype wire

// ----- src/stq_cell.sv -----
// One slot of the sorted chain: holds a wake time and id, shifts with neighbors.
// Depends on stq_pkg.
`default_nettype none
module stq_cell import stq_pkg::*; (
  input  wire logic      clk_i,
  input  wire cell_cmd_t cmd_i,
  input  wire logic      occ_i,
  input  wire logic      left_keep_i,
  input  wire entry_t    left_i,
  input  wire entry_t    right_i,
  output logic           keep_o,
  output entry_t         entry_o
);
  entry_t entry_q, entry_d;

  // occupied and not later than the new word: stays put on insert
  assign keep_o  = occ_i && (entry_q.wake_time <= cmd_i.new_entry.wake_time);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.pop) begin
      entry_d = right_i;
    end else if (cmd_i.ins && !keep_o) begin
      entry_d = left_keep_i ? cmd_i.new_entry : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end
endmodule
`default_nettype wire

// ----- src/stq_chain.sv -----
// Row of stq_cell slots forming the sorted queue, head at slot 0.
// Depends on stq_pkg and stq_cell.
`default_nettype none
module stq_chain import stq_pkg::*; (
  input  wire logic             clk_i,
  input  wire cell_cmd_t        cmd_i,
  input  wire logic [CNT_W-1:0] count_i,
  output entry_t                head_o
);
  entry_t                 ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic   occ;
    logic   lkeep;
    entry_t lent;
    entry_t rent;
    assign occ = CNT_W'(k) < count_i;
    if (k == 0) begin : g_first
      assign lkeep = 1'b1;
      assign lent  = cmd_i.new_entry;
    end else begin : g_mid
      assign lkeep = keep[k-1];
      assign lent  = ent[k-1];
    end
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign rent = ent[k];
    end else begin : g_nxt
      assign rent = ent[k+1];
    end
    stq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .occ_i       (occ),
      .left_keep_i (lkeep),
      .left_i      (lent),
      .right_i     (rent),
      .keep_o      (keep[k]),
      .entry_o     (ent[k])
    );
  end

  assign head_o = ent[0];
endmodule
`default_nettype wire

// ----- sim/sleep_timer_queue_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of sleep_timer_queue: directed table, then random sleep/tick traffic.
// Depends on stq_pkg, stq_if and the sleep_timer_queue RTL.
module sleep_timer_queue_test;
  import stq_pkg::*;

  localparam logic [TIME_W-1:0] TIME_TOP   = '1;
  localparam int unsigned       N_DIR      = 21;
  localparam int unsigned       N_RAND     = 450;   // random words per phase
  localparam int unsigned       HOLD_LEN   = 400;   // long receiver hold-off, cycles
  localparam int unsigned       DRAIN_MAX  = 20000; // bound on the final wait, cycles

  // One result word as the block reports it.
  typedef struct packed {
    status_e         status;
    logic            woke;
    logic [ID_W-1:0] woke_id;
  } reply_t;

  // A typed-in reply, or a request to take the predicted one.
  typedef struct packed {
    bit     typed;
    reply_t reply;
  } reply_pick_t;

  // One row of the directed table.
  typedef struct packed {
    logic                     func;
    logic [ID_W-1:0]          id;
    logic signed [SECS_W-1:0] secs;
    logic [TIME_W-1:0]        now;
    bit                       typed;
    reply_t                   reply;
  } dir_row_t;

  localparam reply_t R_IDLE  = '{ST_OK, 1'b0, '0};
  localparam reply_t R_BAD   = '{ST_BAD_SECONDS, 1'b0, '0};
  localparam reply_t R_SLEPT = '{ST_OK, 1'b0, '0};
  localparam reply_t R_TWICE = '{ST_ASLEEP, 1'b0, '0};

  // func 0 = tick, 1 = sleep. Rows with typed = 0 take the predictor's reply.
  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, 6'd0,  16'h0000, 40'd0,          1'b1, R_IDLE},  // tick on empty queue
    '{1'b1, 6'd0,  16'h0000, 40'd0,          1'b1, R_BAD},   // zero delay
    '{1'b1, 6'd5,  16'h8000, 40'd0,          1'b1, R_BAD},   // most negative delay
    '{1'b1, 6'd5,  16'hFFFF, 40'd0,          1'b1, R_BAD},   // delay of -1
    '{1'b1, 6'd0,  16'h0001, 40'd0,          1'b1, R_SLEPT}, // id zero accepted
    '{1'b1, 6'd0,  16'h0003, 40'd0,          1'b1, R_TWICE}, // id already asleep
    '{1'b1, 6'd0,  16'h0000, 40'd0,          1'b1, R_BAD},   // bad delay wins over asleep
    '{1'b1, 6'd63, 16'h7FFF, TIME_TOP,       1'b1, R_SLEPT}, // wake time saturates
    '{1'b1, 6'd10, 16'h0001, 40'd0,          1'b0, R_IDLE},  // ties with id 0, goes after
    '{1'b1, 6'd42, 16'h7FFF, 40'd0,          1'b0, R_IDLE},
    '{1'b0, 6'd0,  16'h0000, 40'd999999,     1'b0, R_IDLE},  // head not yet due
    '{1'b0, 6'd0,  16'h0000, 40'd1000000,    1'b0, R_IDLE},  // due exactly now
    '{1'b0, 6'd0,  16'h0000, 40'd1000000,    1'b0, R_IDLE},  // tied entry next
    '{1'b0, 6'd0,  16'h0000, TIME_TOP,       1'b0, R_IDLE},  // two due, one popped
    '{1'b0, 6'd0,  16'h0000, TIME_TOP - 1,   1'b0, R_IDLE},  // saturated entry not due
    '{1'b0, 6'd0,  16'h0000, TIME_TOP,       1'b0, R_IDLE},
    '{1'b0, 6'd0,  16'h0000, TIME_TOP,       1'b1, R_IDLE},  // empty again
    '{1'b1, 6'd33, 16'h0001, TIME_TOP - 5,   1'b0, R_IDLE},  // small delay overflows
    '{1'b0, 6'd0,  16'h0000, TIME_TOP,       1'b0, R_IDLE},
    '{1'b1, 6'd21, 16'h5555, 40'h5555555555, 1'b0, R_IDLE},
    '{1'b0, 6'd42, 16'hAAAA, 40'hAAAAAAAAAA, 1'b0, R_IDLE}
  };

  logic clk_i;
  logic rst_ni;

  stq_in_if  sleep_if ();
  stq_out_if result_if ();

  sleep_timer_queue DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sleep_i  (sleep_if),
    .result_o (result_if)
  );

  // Shadow copy of the queue, kept sorted, head at index 0.
  logic [TIME_W-1:0] shadow_time [QUEUE_DEPTH];
  logic [ID_W-1:0]   shadow_id   [QUEUE_DEPTH];
  int unsigned       shadow_count = 0;
  logic [NUM_IDS-1:0] shadow_asleep = '0;

  reply_t      reply_q [$];   // expected result words, oldest first
  reply_pick_t pick_q  [$];   // per sent word: typed reply or predicted
  int unsigned errors = 0;

  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 82;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;
  logic [TIME_W-1:0] sim_now = '0;  // running system time of well-formed traffic

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Predict the reply to one accepted word and update the shadow queue.
  function automatic reply_t predict_reply(input logic func, input logic [ID_W-1:0] id,
                                           input logic signed [SECS_W-1:0] secs,
                                           input logic [TIME_W-1:0] now);
    reply_t            r;
    logic [63:0]       sum;
    logic [TIME_W-1:0] when;
    int unsigned       pos;
    r = '{ST_OK, 1'b0, '0};
    if (func) begin
      if (secs <= 0) begin
        r.status = ST_BAD_SECONDS;
      end else if (shadow_asleep[id]) begin
        r.status = ST_ASLEEP;
      end else if (shadow_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        sum  = 64'(now) + 64'(secs[SECS_W-2:0]) * 64'd1000000;
        when = (sum > 64'(TIME_TOP)) ? TIME_TOP : sum[TIME_W-1:0];
        // new entry goes after all entries with equal wake time
        pos = 0;
        while (pos < shadow_count && shadow_time[pos] <= when) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_time[k] = shadow_time[k-1];
          shadow_id[k]   = shadow_id[k-1];
        end
        shadow_time[pos] = when;
        shadow_id[pos]   = id;
        shadow_count++;
        shadow_asleep[id] = 1'b1;
      end
    end else if (shadow_count != 0 && shadow_time[0] <= now) begin
      // only the head leaves, even when more are due
      r.woke    = 1'b1;
      r.woke_id = shadow_id[0];
      for (int k = 1; k < shadow_count; k++) begin
        shadow_time[k-1] = shadow_time[k];
        shadow_id[k-1]   = shadow_id[k];
      end
      shadow_count--;
      shadow_asleep[r.woke_id] = 1'b0;
    end
    return r;
  endfunction

  // Monitor: both channels sampled at the rising edge, before the block updates.
  always @(posedge clk_i) begin : monitor
    reply_t      got;
    reply_t      want;
    reply_t      pred;
    reply_pick_t pick;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        got = '{status_e'(result_if.status), result_if.woke, result_if.woke_id};
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected: %s woke %0b id %0d",
                                    got.status.name(), got.woke, got.woke_id));
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %s",
                                      result_if.status, want.status.name()));
          if (got.woke !== want.woke)
            report_mismatch($sformatf("woke %0b, expected %0b", got.woke, want.woke));
          if (got.woke_id !== want.woke_id)
            report_mismatch($sformatf("woke_id %0d, expected %0d",
                                      got.woke_id, want.woke_id));
        end
      end
      if (sleep_if.valid && sleep_if.ready) begin
        pick = pick_q.pop_front();
        pred = predict_reply(sleep_if.func, sleep_if.proc_id, sleep_if.sleep_seconds,
                             sleep_if.now_us);
        reply_q.push_back(pick.typed ? pick.reply : pred);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one word; returns once it has been accepted. Valid stays up for the next word.
  task automatic send_word(input logic func, input logic [ID_W-1:0] id,
                           input logic signed [SECS_W-1:0] secs,
                           input logic [TIME_W-1:0] now, input reply_pick_t pick);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      sleep_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pick_q.push_back(pick);
    sleep_if.valid         <= 1'b1;
    sleep_if.func          <= func;
    sleep_if.proc_id       <= id;
    sleep_if.sleep_seconds <= secs;
    sleep_if.now_us        <= now;
    do @(posedge clk_i); while (!sleep_if.ready);
  endtask

  // Random traffic: mostly well-formed sleeps/ticks on a running clock, some noise.
  // Chunks alternate between filling (sleep heavy) and draining (tick heavy).
  task automatic run_random(input int unsigned n);
    logic                     func;
    logic [ID_W-1:0]          id;
    logic signed [SECS_W-1:0] secs;
    logic [TIME_W-1:0]        now;
    int unsigned              sleep_pct;
    int unsigned              r;
    for (int i = 0; i < n; i++) begin
      sleep_pct = ((i / 100) % 2 == 0) ? 75 : 35;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // noise: every field fully random
        func = 1'($urandom);
        id   = ID_W'($urandom);
        secs = SECS_W'($urandom);
        now  = TIME_W'({$urandom, $urandom});
      end else if ($urandom_range(0, 99) < sleep_pct) begin
        func = 1'b1;
        id   = ID_W'($urandom);
        // mostly pick a free id so the queue really fills
        if (shadow_asleep[id] && $urandom_range(0, 99) < 80) begin
          for (int k = 0; k < NUM_IDS; k++) begin
            if (!shadow_asleep[ID_W'(id + k)]) begin
              id = ID_W'(id + k);
              break;
            end
          end
        end
        now = sim_now;
        r   = $urandom_range(0, 99);
        if (r < 80) secs = SECS_W'($urandom_range(1, 8));
        else if (r < 92) secs = SECS_W'($urandom_range(1, 32767));
        else if (r < 96) secs = -$signed(16'($urandom_range(0, 3)));  // invalid
        else begin
          secs = 16'h7FFF;  // near the top of time: saturates
          now  = TIME_TOP - 40'($urandom_range(0, 2_000_000_000));
        end
      end else begin
        func    = 1'b0;
        id      = ID_W'($urandom);
        secs    = SECS_W'($urandom);
        sim_now = sim_now + 40'($urandom_range(0, 2_500_000));
        now     = sim_now;
      end
      send_word(func, id, secs, now, '{1'b0, R_IDLE});
    end
  endtask

  initial begin : stimulus
    int unsigned wait_cycles;
    rst_ni                 <= 1'b0;
    sleep_if.valid         <= 1'b0;
    sleep_if.func          <= 1'b0;
    sleep_if.proc_id       <= '0;
    sleep_if.sleep_seconds <= '0;
    sleep_if.now_us        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Phase 1: sender idles a little, receiver a lot.
    tx_idle_pct = 23;
    rx_idle_pct = 82;
    foreach (dir_rows[i])
      send_word(dir_rows[i].func, dir_rows[i].id, dir_rows[i].secs, dir_rows[i].now,
                '{dir_rows[i].typed, dir_rows[i].reply});
    sim_now = 40'd10_000_000;
    run_random(N_RAND);

    // Phase 2: the other way round.
    tx_idle_pct = 82;
    rx_idle_pct = 23;
    run_random(N_RAND);

    // Phase 3: no idling; the receiver first holds off long enough to stall the input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_random(N_RAND);
    sleep_if.valid <= 1'b0;

    wait_cycles = 0;
    while (reply_q.size() != 0 && wait_cycles < DRAIN_MAX) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (16) @(posedge clk_i);  // catch any stray word after the last one
    if (reply_q.size() != 0)
      report_mismatch($sformatf("%0d expected result words never arrived", reply_q.size()));
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
